/* sv/qrs_pkg.sv */
// qrs_pkg: widths, codes and sideband types shared by the quadratic root solver.
// No dependencies; imported by every module of the block.
`default_nettype none

package qrs_pkg;

    // coefficient width and fraction bits of the roots
    localparam int CW   = 16;
    localparam int F    = 16;
    // discriminant magnitude width (even), square root cells and widths
    localparam int DW   = 2 * CW + 2;
    localparam int SQN  = DW / 2 + F;
    localparam int RTW  = SQN;
    localparam int RMW  = RTW + 2;
    localparam int RADW = 2 * SQN;
    // signed dividend width, divisor width, root width
    localparam int NW   = ((RTW > CW + F + 1) ? RTW : CW + F + 1) + 3;
    localparam int MW   = CW + 1;
    localparam int RW   = CW + F + 2;

    // root count codes
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // discriminant class
    typedef enum logic [1:0] {
        DC_NEG,
        DC_ZERO,
        DC_POS
    } t_dcls;

    // sideband travelling along the square root chain
    typedef struct packed {
        logic                 lin;
        logic                 bnz;
        logic                 a_neg;
        logic                 b_neg;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        logic [MW-1:0]        ma;
        logic [MW-1:0]        mb;
        t_dcls                dcls;
    } t_sq_side;

    // sideband travelling along the divider chains
    typedef struct packed {
        logic [1:0] count;
        logic       neg1;
        logic       neg2;
    } t_dv_side;

endpackage

`default_nettype wire

/* sv/qrs_sqrt_cell.sv */
// qrs_sqrt_cell: one digit of a restoring square root, registered.
// Depends on qrs_pkg for widths.
`default_nettype none

module qrs_sqrt_cell
    import qrs_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [RMW-1:0]  i_rem,
    input  wire logic [RTW-1:0]  i_root,
    input  wire logic [RADW-1:0] i_rad,
    output logic      [RMW-1:0]  o_rem,
    output logic      [RTW-1:0]  o_root,
    output logic      [RADW-1:0] o_rad
);

    logic [RMW-1:0] cur;
    logic [RMW-1:0] trial;
    logic           take;

    // bring down two radicand bits and try root*4+1
    always_comb begin
        cur   = {i_rem[RMW-3:0], i_rad[RADW-1:RADW-2]};
        trial = {i_root, 2'b01};
        take  = (cur >= trial);
    end

    // advance one digit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= take ? (cur - trial) : cur;
            o_root <= {i_root[RTW-2:0], take};
            o_rad  <= {i_rad[RADW-3:0], 2'b00};
        end
    end

endmodule

`default_nettype wire

/* sv/qrs_div_cell.sv */
// qrs_div_cell: one quotient bit of a restoring unsigned divider, registered.
// Depends on qrs_pkg for widths.
`default_nettype none

module qrs_div_cell
    import qrs_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [MW-1:0] i_m,
    input  wire logic [MW-1:0] i_rem,
    input  wire logic [NW-1:0] i_dvd,
    input  wire logic [NW-1:0] i_quo,
    output logic      [MW-1:0] o_m,
    output logic      [MW-1:0] o_rem,
    output logic      [NW-1:0] o_dvd,
    output logic      [NW-1:0] o_quo
);

    logic [MW:0] cur;
    logic [MW:0] diff;
    logic        take;

    // shift in the next dividend bit and try a subtract
    always_comb begin
        cur  = {i_rem, i_dvd[NW-1]};
        diff = cur - {1'b0, i_m};
        take = (cur >= {1'b0, i_m});
    end

    // advance one quotient bit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_m   <= i_m;
            o_rem <= take ? diff[MW-1:0] : cur[MW-1:0];
            o_dvd <= {i_dvd[NW-2:0], 1'b0};
            o_quo <= {i_quo[NW-2:0], take};
        end
    end

endmodule

`default_nettype wire

/* sv/quadratic_root_solver_unit.sv */
// quadratic_root_solver_unit: top level, real roots of a*x^2+b*x+c in Q17.16.
// Depends on qrs_pkg, qrs_sqrt_cell and qrs_div_cell.
//
// Takes one equation per clock while the output is not held and returns one
// word per equation, in order. The stages are an input register, a product
// stage, a discriminant stage, a row of SQN square root cells (one root bit
// each), a dividend setup stage, two parallel rows of NW divider cells (one
// quotient bit each) and the output register. The whole pipeline advances
// together; it holds only while a finished word waits on the output.
`default_nettype none

module quadratic_root_solver_unit
    import qrs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic signed [CW-1:0] i_coef_quad,
    input  wire logic signed [CW-1:0] i_coef_lin,
    input  wire logic signed [CW-1:0] i_coef_const,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [1:0]                o_root_count,
    output logic signed [RW-1:0]      o_first_root,
    output logic signed [RW-1:0]      o_second_root
);

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // ---------------- capture and products ----------------
    logic                   r_v1, r_v2, r_v3;
    logic signed [CW-1:0]   r_a, r_b, r_c;
    logic signed [CW-1:0]   r_a2, r_b2, r_c2;
    logic signed [2*CW-1:0] r_bb, r_ac;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a  <= i_coef_quad;
            r_b  <= i_coef_lin;
            r_c  <= i_coef_const;
            r_a2 <= r_a;
            r_b2 <= r_b;
            r_c2 <= r_c;
            r_bb <= r_b * r_b;
            r_ac <= r_a * r_c;
        end
    end

    // ---------------- discriminant ----------------
    logic signed [2*CW+2:0] d;
    logic signed [CW:0]     a_ext, b_ext;
    t_sq_side               n_sqs;
    logic [RADW-1:0]        n_rad;

    always_comb begin
        d     = signed'({{3{r_bb[2*CW-1]}}, r_bb}) - signed'({r_ac[2*CW-1], r_ac, 2'b00});
        a_ext = signed'({r_a2[CW-1], r_a2});
        b_ext = signed'({r_b2[CW-1], r_b2});
        n_sqs.lin   = (r_a2 == '0);
        n_sqs.bnz   = (r_b2 != '0);
        n_sqs.a_neg = r_a2[CW-1];
        n_sqs.b_neg = r_b2[CW-1];
        n_sqs.b     = r_b2;
        n_sqs.c     = r_c2;
        n_sqs.ma    = MW'(unsigned'(a_ext[CW-1] ? -a_ext : a_ext) << 1);
        n_sqs.mb    = MW'(unsigned'(b_ext[CW-1] ? -b_ext : b_ext));
        if (d[2*CW+2]) begin
            n_sqs.dcls = DC_NEG;
        end else if (d == '0) begin
            n_sqs.dcls = DC_ZERO;
        end else begin
            n_sqs.dcls = DC_POS;
        end
        n_rad = {d[DW-1:0], {(2*F){1'b0}}};
    end

    // ---------------- square root row ----------------
    logic [RMW-1:0]  sq_rem  [0:SQN];
    logic [RTW-1:0]  sq_root [0:SQN];
    logic [RADW-1:0] sq_rad  [0:SQN];
    t_sq_side        r_sqs   [0:SQN];
    logic            r_sqv   [0:SQN];
    logic [RADW-1:0] r_rad0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad0   <= n_rad;
            r_sqs[0] <= n_sqs;
        end
    end
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = r_rad0;

    // hand valid through the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
        end else if (en) begin
            r_v1     <= i_valid;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
        end
    end
    assign r_sqv[0] = r_v3;

    for (genvar k = 0; k < SQN; k++) begin : g_sq
        qrs_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (sq_rem[k]),
            .i_root (sq_root[k]),
            .i_rad  (sq_rad[k]),
            .o_rem  (sq_rem[k+1]),
            .o_root (sq_root[k+1]),
            .o_rad  (sq_rad[k+1])
        );
        // carry sideband alongside the cell
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sqs[k+1] <= r_sqs[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sqv[k+1] <= 1'b0;
            end else if (en) begin
                r_sqv[k+1] <= r_sqv[k];
            end
        end
    end

    // ---------------- dividend setup ----------------
    t_sq_side             sq;
    logic signed [NW-1:0] nb, nn, nt, ne, nc, y1, y2;
    logic [MW-1:0]        n_m;
    t_dv_side             n_dvs;

    always_comb begin
        sq = r_sqs[SQN];
        nb = signed'({{(NW-CW){sq.b[CW-1]}}, sq.b});
        nc = signed'({{(NW-CW){sq.c[CW-1]}}, sq.c});
        nn = -(nb <<< F);
        nt = signed'({{(NW-RTW){1'b0}}, sq_root[SQN]});
        ne = signed'(NW'(sq_rem[SQN] != '0));
        y1 = '0;
        y2 = '0;
        n_m = sq.ma;
        n_dvs.count = CNT_NONE;
        if (sq.lin) begin
            n_m = sq.mb;
            if (sq.bnz) begin
                n_dvs.count = CNT_ONE;
                y1 = sq.b_neg ? (nc <<< F) : -(nc <<< F);
            end
        end else begin
            case (sq.dcls)
                DC_ZERO: begin
                    n_dvs.count = CNT_ONE;
                    y1 = sq.a_neg ? -nn : nn;
                end
                DC_POS: begin
                    n_dvs.count = CNT_TWO;
                    if (sq.a_neg) begin
                        y1 = nt - nn;
                        y2 = -(nn + nt + ne);
                    end else begin
                        y1 = nn - nt - ne;
                        y2 = nn + nt;
                    end
                end
                default: begin
                    n_dvs.count = CNT_NONE;
                end
            endcase
        end
        n_dvs.neg1 = y1[NW-1];
        n_dvs.neg2 = y2[NW-1];
    end

    // ---------------- divider rows ----------------
    logic [MW-1:0] d1_m [0:NW], d1_rem [0:NW], d2_m [0:NW], d2_rem [0:NW];
    logic [NW-1:0] d1_dvd [0:NW], d1_quo [0:NW], d2_dvd [0:NW], d2_quo [0:NW];
    t_dv_side      r_dvs [0:NW];
    logic          r_dvv [0:NW];
    logic [MW-1:0] r_m0;
    logic [NW-1:0] r_y1, r_y2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m0     <= n_m;
            r_y1     <= unsigned'(y1[NW-1] ? -y1 : y1);
            r_y2     <= unsigned'(y2[NW-1] ? -y2 : y2);
            r_dvs[0] <= n_dvs;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvv[0] <= 1'b0;
        end else if (en) begin
            r_dvv[0] <= r_sqv[SQN];
        end
    end
    assign d1_m[0]   = r_m0;
    assign d2_m[0]   = r_m0;
    assign d1_rem[0] = '0;
    assign d2_rem[0] = '0;
    assign d1_dvd[0] = r_y1;
    assign d2_dvd[0] = r_y2;
    assign d1_quo[0] = '0;
    assign d2_quo[0] = '0;

    for (genvar k = 0; k < NW; k++) begin : g_dv
        qrs_div_cell u_first (
            .i_clk (i_clk),
            .i_en  (en),
            .i_m   (d1_m[k]),
            .i_rem (d1_rem[k]),
            .i_dvd (d1_dvd[k]),
            .i_quo (d1_quo[k]),
            .o_m   (d1_m[k+1]),
            .o_rem (d1_rem[k+1]),
            .o_dvd (d1_dvd[k+1]),
            .o_quo (d1_quo[k+1])
        );
        qrs_div_cell u_second (
            .i_clk (i_clk),
            .i_en  (en),
            .i_m   (d2_m[k]),
            .i_rem (d2_rem[k]),
            .i_dvd (d2_dvd[k]),
            .i_quo (d2_quo[k]),
            .o_m   (d2_m[k+1]),
            .o_rem (d2_rem[k+1]),
            .o_dvd (d2_dvd[k+1]),
            .o_quo (d2_quo[k+1])
        );
        // carry sideband alongside the cells
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dvs[k+1] <= r_dvs[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvv[k+1] <= 1'b0;
            end else if (en) begin
                r_dvv[k+1] <= r_dvv[k];
            end
        end
    end

    // ---------------- floor correction and output word ----------------
    t_dv_side             dv;
    logic signed [NW-1:0] q1, q2;

    always_comb begin
        dv = r_dvs[NW];
        q1 = dv.neg1 ? -signed'(d1_quo[NW] + NW'(d1_rem[NW] != '0)) : signed'(d1_quo[NW]);
        q2 = dv.neg2 ? -signed'(d2_quo[NW] + NW'(d2_rem[NW] != '0)) : signed'(d2_quo[NW]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_root_count  <= dv.count;
            o_first_root  <= (dv.count == CNT_NONE) ? '0 : q1[RW-1:0];
            o_second_root <= (dv.count == CNT_TWO) ? q2[RW-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_dvv[NW];
        end
    end

    // ---------------- checks ----------------
    a_none_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_root_count == CNT_NONE) |-> (o_first_root == '0 && o_second_root == '0))
        else $error("root fields not zero with no root");

    a_second_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_root_count != CNT_TWO) |-> (o_second_root == '0))
        else $error("second root set without two roots");

    a_count_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_root_count <= CNT_TWO))
        else $error("illegal root count");

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_root_count)
            && $stable(o_first_root) && $stable(o_second_root)))
        else $error("output word changed while waiting");

endmodule

`default_nettype wire
